@@ rtl/ihdna_pkg.sv @@
// Shared constants, register indexes and the channel averaging function of the downscaler.
`timescale 1ns / 1ps

package ihdna_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIX_BITS       = 8;
    localparam int RGB_BITS       = 3 * PIX_BITS;
    localparam int WIDTH_BITS     = 12;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_index;

    typedef logic [PIX_BITS-1:0] t_chan;

    // Sum of up to five samples, divided by four and saturated to a byte.
    function automatic t_chan avg_chan(input t_chan self_px, input t_chan below,
                                       input t_chan right, input t_chan above,
                                       input t_chan left, input logic use_above,
                                       input logic use_left);
        logic [PIX_BITS+2:0] sum;
        logic [PIX_BITS:0]   quarter;
        begin
            sum = {3'b000, self_px} + {3'b000, below} + {3'b000, right};
            if (use_above) begin
                sum = sum + {3'b000, above};
            end
            if (use_left) begin
                sum = sum + {3'b000, left};
            end
            quarter = sum[PIX_BITS+2:2];
            if (quarter[PIX_BITS]) begin
                avg_chan = '1;
            end else begin
                avg_chan = quarter[PIX_BITS-1:0];
            end
        end
    endfunction

endpackage

@@ rtl/image_half_downscale_neighbor_avg_unit.sv @@
// Top level of the downscale-by-two neighbor averaging unit with its line memory.
`timescale 1ns / 1ps

// Path: the request that carries the pixel below the center pixel waits in stage one while
// its memory word is read, then the averaged result enters the output register.
// Throughput: one pixel request per cycle; the line memory takes one write and one read
// per cycle, and a request stalls only while a finished result waits on a stalled output.
// Reset: counters return to the frame start, width and height to 640 and 480; the line
// memory is not cleared and holds unknown data until a frame writes it.
module image_half_downscale_neighbor_avg_unit
    import ihdna_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_pix_valid,
    output logic                      o_pix_stall,
    input  logic [PIX_BITS-1:0]       i_pix_red,
    input  logic [PIX_BITS-1:0]       i_pix_green,
    input  logic [PIX_BITS-1:0]       i_pix_blue,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [PIX_BITS-1:0]       o_out_red,
    output logic [PIX_BITS-1:0]       o_out_green,
    output logic [PIX_BITS-1:0]       o_out_blue,
    output logic                      o_row_end,
    output logic                      o_frame_end,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // Column counter width, and a width for comparing columns against the frame width
    // that can hold both the width register and MAX_WIDTH itself.
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = (WIDTH_BITS > CW + 1) ? WIDTH_BITS : CW + 1;
    localparam int DEPTH = MAX_WIDTH / 2;

    // Each memory word covers one even/odd column pair and holds four lanes:
    // the center line (last even source row) and the upper line (last odd row).
    localparam int LANE_CTR_EVEN = 0;
    localparam int LANE_CTR_ODD  = 1;
    localparam int LANE_UP_EVEN  = 2;
    localparam int LANE_UP_ODD   = 3;
    localparam int WORD_BITS     = 4 * RGB_BITS;

    logic [WORD_BITS-1:0]   r_line_mem [DEPTH];
    logic [WORD_BITS-1:0]   r_rd_word;

    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [CW-1:0]          r_col;
    logic [HEIGHT_BITS-1:0] r_row;

    // Stage one: the request waits here while its memory word is read.
    logic                   r_s1_valid;
    logic [RGB_BITS-1:0]    r_s1_below;
    logic                   r_s1_use_above;
    logic                   r_s1_use_left;
    logic                   r_s1_row_end;
    logic                   r_s1_frame_end;
    logic [RGB_BITS-1:0]    r_left;

    logic                   r_out_valid;
    logic [PIX_BITS-1:0]    r_out_red;
    logic [PIX_BITS-1:0]    r_out_green;
    logic [PIX_BITS-1:0]    r_out_blue;
    logic                   r_out_row_end;
    logic                   r_out_frame_end;

    logic                   pix_accept;
    logic                   s1_advance;
    logic                   emit;
    logic                   emit_accept;
    logic                   rd_accept;
    logic [RGB_BITS-1:0]    pix_word;
    logic [CW-2:0]          mem_addr;

    logic [EW-1:0]          width_ext;
    logic [EW-1:0]          width_eff;
    logic [EW-1:0]          out_width;
    logic [EW-1:0]          col_half;
    logic [EW-1:0]          col_next;
    logic [HEIGHT_BITS-1:0] height_eff;
    logic [HEIGHT_BITS-1:0] out_height;
    logic [HEIGHT_BITS-1:0] row_half;
    logic [HEIGHT_BITS:0]   row_next;
    logic                   col_last;
    logic                   row_last;
    logic                   hit_row_end;

    logic [RGB_BITS-1:0]    rd_self;
    logic [RGB_BITS-1:0]    rd_right;
    logic [RGB_BITS-1:0]    rd_above;

    assign pix_word = {i_pix_blue, i_pix_green, i_pix_red};
    assign mem_addr = r_col[CW-1:1];

    // Effective frame size: width limited to the line memory, zero sizes read as one.
    always_comb begin
        width_ext = EW'(r_width);
        if (width_ext > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else if (width_ext == '0) begin
            width_eff = EW'(1);
        end else begin
            width_eff = width_ext;
        end
        if (r_height == '0) begin
            height_eff = HEIGHT_BITS'(1);
        end else begin
            height_eff = r_height;
        end
        out_width  = width_eff >> 1;
        out_height = height_eff >> 1;
        col_half   = EW'(r_col[CW-1:1]);
        row_half   = r_row >> 1;
        col_next   = EW'(r_col) + EW'(1);
        row_next   = {1'b0, r_row} + (HEIGHT_BITS + 1)'(1);
        col_last   = col_next >= width_eff;
        row_last   = row_next >= {1'b0, height_eff};
    end

    // A result is due when the pixel below an even-column center pixel arrives on an
    // odd source row, and only inside the output frame; odd leftover rows and columns
    // are stored as neighbors but never produce a result of their own.
    assign emit        = r_row[0] && !r_col[0] && (col_half < out_width)
                         && (row_half < out_height);
    assign hit_row_end = col_half == (out_width - EW'(1));

    // The output register takes a new result when it is empty or being drained. A
    // request waits only while stage one holds a result that cannot move on.
    assign s1_advance  = !r_out_valid || !i_out_stall;
    assign o_pix_stall = r_s1_valid && !s1_advance;
    assign pix_accept  = i_pix_valid && !o_pix_stall;
    assign emit_accept = pix_accept && emit;

    // Every even column of an odd row reads its word, whether or not it gives a result,
    // so that the left neighbor of the next pair is always at hand.
    assign rd_accept   = pix_accept && r_row[0] && !r_col[0];

    // Line memory: each request writes its pixel into one lane; the read happens in
    // the same cycle and returns the word as it was before that write, so the upper
    // pixel of the current column is seen before it is replaced by the new pixel.
    // Center lanes are written only on even rows and read only on odd rows, so reads
    // and writes of the same lane never meet.
    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            if (!r_row[0]) begin
                if (r_col[0]) begin
                    r_line_mem[mem_addr][LANE_CTR_ODD*RGB_BITS +: RGB_BITS] <= pix_word;
                end else begin
                    r_line_mem[mem_addr][LANE_CTR_EVEN*RGB_BITS +: RGB_BITS] <= pix_word;
                end
            end else begin
                if (r_col[0]) begin
                    r_line_mem[mem_addr][LANE_UP_ODD*RGB_BITS +: RGB_BITS] <= pix_word;
                end else begin
                    r_line_mem[mem_addr][LANE_UP_EVEN*RGB_BITS +: RGB_BITS] <= pix_word;
                end
            end
        end
        if (rd_accept) begin
            r_rd_word <= r_line_mem[mem_addr];
        end
    end

    // Configuration registers; writes to unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_index'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[WIDTH_BITS-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position of the next pixel. A position left outside a shrunken frame
    // wraps to the start of the next row or frame on the next request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_next[HEIGHT_BITS-1:0];
                end
            end else begin
                r_col <= col_next[CW-1:0];
            end
        end
    end

    // Stage one control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (emit_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_accept) begin
            r_s1_below     <= pix_word;
            r_s1_use_above <= r_row >= HEIGHT_BITS'(3);
            r_s1_use_left  <= r_col[CW-1:1] != '0;
            r_s1_row_end   <= hit_row_end;
            r_s1_frame_end <= hit_row_end && (row_half == (out_height - HEIGHT_BITS'(1)));
        end
    end

    // The left neighbor of a center pixel is the odd center lane of the previous
    // pair, fetched by the read two columns earlier on the same row. It is taken over
    // at the edge of the next read, when any result still in stage one leaves.
    assign rd_self  = r_rd_word[LANE_CTR_EVEN*RGB_BITS +: RGB_BITS];
    assign rd_right = r_rd_word[LANE_CTR_ODD*RGB_BITS +: RGB_BITS];
    assign rd_above = r_rd_word[LANE_UP_EVEN*RGB_BITS +: RGB_BITS];

    always_ff @(posedge i_clk) begin
        if (rd_accept) begin
            r_left <= rd_right;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_advance) begin
            r_out_red       <= avg_chan(rd_self[0 +: PIX_BITS], r_s1_below[0 +: PIX_BITS],
                                        rd_right[0 +: PIX_BITS], rd_above[0 +: PIX_BITS],
                                        r_left[0 +: PIX_BITS], r_s1_use_above,
                                        r_s1_use_left);
            r_out_green     <= avg_chan(rd_self[PIX_BITS +: PIX_BITS],
                                        r_s1_below[PIX_BITS +: PIX_BITS],
                                        rd_right[PIX_BITS +: PIX_BITS],
                                        rd_above[PIX_BITS +: PIX_BITS],
                                        r_left[PIX_BITS +: PIX_BITS], r_s1_use_above,
                                        r_s1_use_left);
            r_out_blue      <= avg_chan(rd_self[2*PIX_BITS +: PIX_BITS],
                                        r_s1_below[2*PIX_BITS +: PIX_BITS],
                                        rd_right[2*PIX_BITS +: PIX_BITS],
                                        rd_above[2*PIX_BITS +: PIX_BITS],
                                        r_left[2*PIX_BITS +: PIX_BITS], r_s1_use_above,
                                        r_s1_use_left);
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule
